>>> hw/rtl/ccsbm_pkg.sv
// Shared types and constants for the cut cycle sequencer with button menu.
// Holds the register map, the reset values and the state structs.
// No dependencies.
package ccsbm_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_MS   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_MS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FEED_MS_UNIT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SERVO_HOLD_MS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CUT_POSITION  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REST_POSITION = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH_MAX    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_QUANTITY_MAX  = 3'd7;

  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;
  localparam logic [7:0]  FEED_MS_UNIT_RST  = 8'd30;
  localparam logic [15:0] SERVO_HOLD_MS_RST = 16'd500;
  localparam logic [7:0]  CUT_POSITION_RST  = 8'd20;
  localparam logic [7:0]  REST_POSITION_RST = 8'd9;
  localparam logic [5:0]  LENGTH_MAX_RST    = 6'd20;
  localparam logic [5:0]  QUANTITY_MAX_RST  = 6'd50;

  // Lowest value of the length and quantity settings, and the quantity step.
  localparam logic [5:0] SETTING_MIN   = 6'd5;
  localparam logic [5:0] QUANTITY_STEP = 6'd5;

  localparam logic [1:0] PAGE_START    = 2'd0;
  localparam logic [1:0] PAGE_LENGTH   = 2'd1;
  localparam logic [1:0] PAGE_QUANTITY = 2'd2;

  typedef enum logic [1:0] {
    PH_START,
    PH_FEED,
    PH_CUT,
    PH_LIFT
  } cut_phase_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [7:0]  feed_ms_per_unit;
    logic [15:0] servo_hold_ms;
    logic [7:0]  cut_position;
    logic [7:0]  rest_position;
    logic [5:0]  length_max;
    logic [5:0]  quantity_max;
  } cfg_t;

  typedef struct packed {
    logic [31:0] key_time;
    logic        pressed;
    logic        long_press;
    logic [1:0]  page;
  } key_st_t;

  typedef struct packed {
    logic       run;
    logic [5:0] length;
    logic [5:0] quantity;
    logic [5:0] preset;
    logic       stopped;
    logic       pause_phase;
  } menu_st_t;

  typedef struct packed {
    cut_phase_t  phase;
    logic [31:0] phase_start;
    logic        motor;
    logic        pwm;
    logic [7:0]  compare;
  } seq_st_t;

endpackage

>>> hw/rtl/ccsbm_button.sv
// Debounce, long-press page stepping and short-press menu actions.
// Combinational; depends on ccsbm_pkg.
module ccsbm_button import ccsbm_pkg::*; (
  input  logic [31:0] now,
  input  logic        level,
  input  cfg_t        cfg,
  input  key_st_t     key_cur,
  input  menu_st_t    menu_cur,
  output key_st_t     key_nxt,
  output menu_st_t    menu_nxt
);

  logic [31:0] elapsed;
  logic        deb_over;
  logic        long_over;
  logic [6:0]  len_inc;
  logic [6:0]  qty_inc;

  assign elapsed   = now - key_cur.key_time;
  assign deb_over  = elapsed > {16'd0, cfg.debounce_ms};
  assign long_over = elapsed > {16'd0, cfg.long_press_ms};
  assign len_inc   = {1'b0, menu_cur.length} + 7'd1;
  assign qty_inc   = {1'b0, menu_cur.quantity} + {1'b0, QUANTITY_STEP};

  always_comb begin
    key_nxt  = key_cur;
    menu_nxt = menu_cur;
    priority if (!level && !key_cur.pressed && deb_over) begin
      key_nxt.pressed    = 1'b1;
      key_nxt.long_press = 1'b0;
      key_nxt.key_time   = now;
    end else if (!level && !key_cur.long_press && long_over) begin
      key_nxt.long_press = 1'b1;
      key_nxt.page       = (key_cur.page >= PAGE_QUANTITY) ? PAGE_START
                                                           : key_cur.page + 2'd1;
    end else if (level && key_cur.pressed && deb_over) begin
      key_nxt.pressed  = 1'b0;
      key_nxt.key_time = now;
      if (!key_cur.long_press) begin
        unique case (key_cur.page)
          PAGE_START: begin
            menu_nxt.run = !menu_cur.run;
            if (!menu_cur.run) begin
              menu_nxt.stopped     = 1'b0;
              menu_nxt.pause_phase = 1'b0;
            end
          end
          PAGE_LENGTH: begin
            menu_nxt.length = (len_inc > {1'b0, cfg.length_max}) ? SETTING_MIN
                                                                 : len_inc[5:0];
          end
          PAGE_QUANTITY: begin
            menu_nxt.quantity = (qty_inc > {1'b0, cfg.quantity_max}) ? SETTING_MIN
                                                                     : qty_inc[5:0];
            menu_nxt.preset   = menu_nxt.quantity;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/ccsbm_cut_seq.sv
// Feed, cut and lift sequencer and the pause sequence.
// Combinational; depends on ccsbm_pkg.
module ccsbm_cut_seq import ccsbm_pkg::*; (
  input  logic [31:0] now,
  input  cfg_t        cfg,
  input  menu_st_t    menu_cur,
  input  seq_st_t     seq_cur,
  output menu_st_t    menu_nxt,
  output seq_st_t     seq_nxt
);

  logic [31:0] elapsed;
  logic [13:0] feed_time;
  logic        feed_done;
  logic        hold_done;
  logic        active;
  cut_phase_t  phase_nxt;

  assign elapsed   = now - seq_cur.phase_start;
  assign feed_time = 14'(menu_cur.length) * 14'(cfg.feed_ms_per_unit);
  assign feed_done = elapsed > {18'd0, feed_time};
  assign hold_done = elapsed > {16'd0, cfg.servo_hold_ms};
  assign active    = menu_cur.run;

  // Next phase.
  always_comb begin
    phase_nxt = seq_cur.phase;
    if (!active) begin
      if (!menu_cur.stopped) begin
        phase_nxt = PH_START;
      end
    end else begin
      unique case (seq_cur.phase)
        PH_START: phase_nxt = PH_FEED;
        PH_FEED:  phase_nxt = feed_done ? PH_CUT : PH_FEED;
        PH_CUT:   phase_nxt = hold_done ? PH_LIFT : PH_CUT;
        PH_LIFT:  phase_nxt = hold_done ? PH_START : PH_LIFT;
        default:  phase_nxt = PH_START;
      endcase
    end
  end

  // Drives, timers and piece count.
  always_comb begin
    menu_nxt      = menu_cur;
    seq_nxt       = seq_cur;
    seq_nxt.phase = phase_nxt;
    if (active) begin
      unique case (seq_cur.phase)
        PH_START: begin
          seq_nxt.phase_start = now;
          seq_nxt.motor       = 1'b1;
        end
        PH_FEED: begin
          if (feed_done) begin
            seq_nxt.motor       = 1'b0;
            seq_nxt.phase_start = now;
            seq_nxt.pwm         = 1'b1;
            seq_nxt.compare     = cfg.cut_position;
          end
        end
        PH_CUT: begin
          if (hold_done) begin
            seq_nxt.compare     = cfg.rest_position;
            seq_nxt.phase_start = now;
          end
        end
        PH_LIFT: begin
          if (hold_done) begin
            seq_nxt.pwm = 1'b0;
            if (menu_cur.quantity <= 6'd1) begin
              menu_nxt.quantity = menu_cur.preset;
              menu_nxt.run      = 1'b0;
            end else begin
              menu_nxt.quantity = menu_cur.quantity - 6'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (!menu_cur.stopped) begin
      if (!menu_cur.pause_phase) begin
        seq_nxt.motor        = 1'b0;
        seq_nxt.phase_start  = now;
        seq_nxt.compare      = cfg.rest_position;
        menu_nxt.pause_phase = 1'b1;
      end else if (hold_done) begin
        seq_nxt.pwm          = 1'b0;
        menu_nxt.pause_phase = 1'b0;
        menu_nxt.stopped     = 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/cut_cycle_sequencer_with_button_menu.sv
// Cut cycle sequencer with a one-button menu: top level with all state registers.
// Uses ccsbm_pkg, ccsbm_button and ccsbm_cut_seq.
// Path: an accepted tick beat is held in the input register, then placed in the state/result registers.
// Throughput: one tick beat per cycle; the input register and the state/result
// registers advance together whenever the result slot is empty or being taken.
// Reset: synchronous active-low rst_n restores all settings and all state but the held button sample to their defaults.
module cut_cycle_sequencer_with_button_menu import ccsbm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_button_level,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_motor_on,
  output logic                out_servo_enabled,
  output logic [7:0]          out_servo_compare,
  output logic                out_status_led,
  output logic                out_running,
  output logic [1:0]          out_menu_page,
  output logic [5:0]          out_length_setting,
  output logic [5:0]          out_quantity_left
);

  // Configuration registers.
  cfg_t cfg_r;

  // Input stage: one button sample waiting for the update stage.
  logic in_valid_r;
  logic level_r;

  // Tick state. These registers also serve as the result register, so they only
  // move when a beat can be placed in the result slot.
  logic [31:0] now_r;
  key_st_t     key_r;
  menu_st_t    menu_r;
  seq_st_t     seq_r;
  logic        led_r;
  logic        out_valid_r;

  logic        advance;
  logic        in_take;
  logic [31:0] now_nxt;
  key_st_t     key_nxt;
  menu_st_t    menu_btn;
  menu_st_t    menu_nxt;
  seq_st_t     seq_nxt;

  // The update stage fires when a sample is held and the result slot is free
  // or being emptied in this cycle.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Every tick first moves the millisecond clock on by one.
  assign now_nxt = now_r + 32'd1;

  ccsbm_button u_button (
    .now      (now_nxt),
    .level    (level_r),
    .cfg      (cfg_r),
    .key_cur  (key_r),
    .menu_cur (menu_r),
    .key_nxt  (key_nxt),
    .menu_nxt (menu_btn)
  );

  // The cut sequencer sees the menu state after this tick's button action.
  ccsbm_cut_seq u_cut_seq (
    .now      (now_nxt),
    .cfg      (cfg_r),
    .menu_cur (menu_btn),
    .seq_cur  (seq_r),
    .menu_nxt (menu_nxt),
    .seq_nxt  (seq_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= DEBOUNCE_MS_RST;
      cfg_r.long_press_ms    <= LONG_PRESS_MS_RST;
      cfg_r.feed_ms_per_unit <= FEED_MS_UNIT_RST;
      cfg_r.servo_hold_ms    <= SERVO_HOLD_MS_RST;
      cfg_r.cut_position     <= CUT_POSITION_RST;
      cfg_r.rest_position    <= REST_POSITION_RST;
      cfg_r.length_max       <= LENGTH_MAX_RST;
      cfg_r.quantity_max     <= QUANTITY_MAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS:   cfg_r.debounce_ms      <= cfg_wdata;
        CFG_LONG_PRESS_MS: cfg_r.long_press_ms    <= cfg_wdata;
        CFG_FEED_MS_UNIT:  cfg_r.feed_ms_per_unit <= cfg_wdata[7:0];
        CFG_SERVO_HOLD_MS: cfg_r.servo_hold_ms    <= cfg_wdata;
        CFG_CUT_POSITION:  cfg_r.cut_position     <= cfg_wdata[7:0];
        CFG_REST_POSITION: cfg_r.rest_position    <= cfg_wdata[7:0];
        CFG_LENGTH_MAX:    cfg_r.length_max       <= cfg_wdata[5:0];
        CFG_QUANTITY_MAX:  cfg_r.quantity_max     <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      level_r <= in_button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // All tick state is control state here, so all of it is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r               <= 32'd0;
      key_r.key_time      <= 32'd0;
      key_r.pressed       <= 1'b0;
      key_r.long_press    <= 1'b0;
      key_r.page          <= PAGE_START;
      menu_r.run          <= 1'b0;
      menu_r.length       <= SETTING_MIN;
      menu_r.quantity     <= SETTING_MIN;
      menu_r.preset       <= SETTING_MIN;
      menu_r.stopped      <= 1'b0;
      menu_r.pause_phase  <= 1'b0;
      seq_r.phase         <= PH_START;
      seq_r.phase_start   <= 32'd0;
      seq_r.motor         <= 1'b0;
      seq_r.pwm           <= 1'b0;
      seq_r.compare       <= 8'd0;
      led_r               <= 1'b1;
    end else if (advance) begin
      now_r  <= now_nxt;
      key_r  <= key_nxt;
      menu_r <= menu_nxt;
      seq_r  <= seq_nxt;
      // The lamp follows the run flag as it stands after the button action,
      // before the cut sequencer may end the run.
      led_r  <= !menu_btn.run;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motor_on       = seq_r.motor;
  assign out_servo_enabled  = seq_r.pwm;
  assign out_servo_compare  = seq_r.compare;
  assign out_status_led     = led_r;
  assign out_running        = menu_r.run;
  assign out_menu_page      = key_r.page;
  assign out_length_setting = menu_r.length;
  assign out_quantity_left  = menu_r.quantity;

endmodule

>>> tb/sv/cutter_behavior_check.sv
`timescale 1ns / 100ps
// Behavior checker for the cut cycle sequencer: follows the register writes and
// the tick beats, predicts every result beat and compares it with the block.
// Depends on ccsbm_pkg for the register map, reset values and phase enum.
module cutter_behavior_check import ccsbm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_button_level,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_motor_on,
  input  logic                out_servo_enabled,
  input  logic [7:0]          out_servo_compare,
  input  logic                out_status_led,
  input  logic                out_running,
  input  logic [1:0]          out_menu_page,
  input  logic [5:0]          out_length_setting,
  input  logic [5:0]          out_quantity_left,
  output int                  mismatch_count,
  output int                  waiting_count,
  output int                  ticks_seen,
  output int                  runs_started,
  output int                  pieces_cut,
  output int                  page_steps
);

  typedef struct packed {
    logic       motor;
    logic       servo_en;
    logic [7:0] compare;
    logic       led;
    logic       running;
    logic [1:0] page;
    logic [5:0] length;
    logic [5:0] quantity;
  } panel_t;

  cfg_t        settings;
  logic [31:0] ms_now, key_stamp, seq_stamp;
  logic        key_down, key_long, is_running, halt_step, halt_done;
  logic        motor_q, pwm_q;
  logic [7:0]  compare_q;
  logic [1:0]  cur_page;
  logic [5:0]  len_units, qty_left, qty_preset;
  cut_phase_t  seq_phase;
  panel_t      panel_queue[$];
  int          fault_total;

  function automatic void restore_defaults();
    settings = '{debounce_ms: DEBOUNCE_MS_RST, long_press_ms: LONG_PRESS_MS_RST,
                 feed_ms_per_unit: FEED_MS_UNIT_RST, servo_hold_ms: SERVO_HOLD_MS_RST,
                 cut_position: CUT_POSITION_RST, rest_position: REST_POSITION_RST,
                 length_max: LENGTH_MAX_RST, quantity_max: QUANTITY_MAX_RST};
    ms_now = '0;
    key_stamp = '0;
    seq_stamp = '0;
    key_down = 1'b0;
    key_long = 1'b0;
    is_running = 1'b0;
    halt_step = 1'b0;
    halt_done = 1'b0;
    motor_q = 1'b0;
    pwm_q = 1'b0;
    compare_q = '0;
    cur_page = PAGE_START;
    len_units = SETTING_MIN;
    qty_left = SETTING_MIN;
    qty_preset = SETTING_MIN;
    seq_phase = PH_START;
  endfunction

  // A short press acts on the page shown. Sums are taken at 32 bits so that
  // a setting near 63 overflows into the wrap instead of into the 6-bit field.
  function automatic void apply_short_press();
    logic [31:0] sum;
    case (cur_page)
      PAGE_START: begin
        is_running = ~is_running;
        if (is_running) begin
          halt_done = 1'b0;
          halt_step = 1'b0;
          runs_started++;
        end
      end
      PAGE_LENGTH: begin
        sum = len_units + 32'd1;
        len_units = (sum > settings.length_max) ? SETTING_MIN : sum[5:0];
      end
      PAGE_QUANTITY: begin
        sum = qty_left + QUANTITY_STEP;
        qty_left = (sum > settings.quantity_max) ? SETTING_MIN : sum[5:0];
        qty_preset = qty_left;
      end
      default: ;
    endcase
  endfunction

  // One millisecond of the block: button, then either the cut cycle or the
  // stop sequence. The lamp is taken between the two.
  function automatic panel_t advance_one_ms(logic level);
    logic [31:0] key_age, seq_age;
    logic        led;
    panel_t      p;
    ms_now = ms_now + 32'd1;
    key_age = ms_now - key_stamp;
    if (!level && !key_down && key_age > settings.debounce_ms) begin
      key_down = 1'b1;
      key_long = 1'b0;
      key_stamp = ms_now;
    end else if (!level && !key_long && key_age > settings.long_press_ms) begin
      key_long = 1'b1;
      cur_page = (cur_page >= PAGE_QUANTITY) ? PAGE_START : cur_page + 2'd1;
      page_steps++;
    end else if (level && key_down && key_age > settings.debounce_ms) begin
      key_down = 1'b0;
      key_stamp = ms_now;
      if (!key_long) apply_short_press();
    end

    led = ~is_running;
    if (is_running) begin
      seq_age = ms_now - seq_stamp;
      case (seq_phase)
        PH_START: begin
          seq_stamp = ms_now;
          motor_q = 1'b1;
          seq_phase = PH_FEED;
        end
        PH_FEED: begin
          if (seq_age > len_units * settings.feed_ms_per_unit) begin
            motor_q = 1'b0;
            seq_stamp = ms_now;
            pwm_q = 1'b1;
            compare_q = settings.cut_position;
            seq_phase = PH_CUT;
          end
        end
        PH_CUT: begin
          if (seq_age > settings.servo_hold_ms) begin
            compare_q = settings.rest_position;
            seq_stamp = ms_now;
            seq_phase = PH_LIFT;
          end
        end
        default: begin
          if (seq_age > settings.servo_hold_ms) begin
            pwm_q = 1'b0;
            seq_phase = PH_START;
            pieces_cut++;
            if (qty_left <= 6'd1) begin
              qty_left = qty_preset;
              is_running = 1'b0;
            end else begin
              qty_left = qty_left - 6'd1;
            end
          end
        end
      endcase
    end else if (!halt_done) begin
      seq_phase = PH_START;
      if (!halt_step) begin
        motor_q = 1'b0;
        seq_stamp = ms_now;
        compare_q = settings.rest_position;
        halt_step = 1'b1;
      end else if (ms_now - seq_stamp > settings.servo_hold_ms) begin
        pwm_q = 1'b0;
        halt_step = 1'b0;
        halt_done = 1'b1;
      end
    end

    p = '{motor: motor_q, servo_en: pwm_q, compare: compare_q, led: led,
          running: is_running, page: cur_page, length: len_units, quantity: qty_left};
    return p;
  endfunction

  always @(posedge clk) begin
    panel_t got, want;
    string  bad;
    if (!rst_n) begin
      restore_defaults();
      panel_queue.delete();
      fault_total = 0;
      ticks_seen = 0;
      runs_started = 0;
      pieces_cut = 0;
      page_steps = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DEBOUNCE_MS:   settings.debounce_ms = cfg_wdata;
          CFG_LONG_PRESS_MS: settings.long_press_ms = cfg_wdata;
          CFG_FEED_MS_UNIT:  settings.feed_ms_per_unit = cfg_wdata[7:0];
          CFG_SERVO_HOLD_MS: settings.servo_hold_ms = cfg_wdata;
          CFG_CUT_POSITION:  settings.cut_position = cfg_wdata[7:0];
          CFG_REST_POSITION: settings.rest_position = cfg_wdata[7:0];
          CFG_LENGTH_MAX:    settings.length_max = cfg_wdata[5:0];
          CFG_QUANTITY_MAX:  settings.quantity_max = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        panel_queue.push_back(advance_one_ms(in_button_level));
        ticks_seen++;
      end
      if (out_valid && !out_stall) begin
        got = '{motor: out_motor_on, servo_en: out_servo_enabled, compare: out_servo_compare,
                led: out_status_led, running: out_running, page: out_menu_page,
                length: out_length_setting, quantity: out_quantity_left};
        if (panel_queue.size() == 0) begin
          fault_total++;
          if (fault_total <= 10)
            $display("[%0t] result beat with no tick waiting: %p", $realtime, got);
        end else begin
          want = panel_queue.pop_front();
          bad = "";
          if (got.motor !== want.motor)       bad = {bad, " motor_on"};
          if (got.servo_en !== want.servo_en) bad = {bad, " servo_enabled"};
          if (got.compare !== want.compare)   bad = {bad, " servo_compare"};
          if (got.led !== want.led)           bad = {bad, " status_led"};
          if (got.running !== want.running)   bad = {bad, " running"};
          if (got.page !== want.page)         bad = {bad, " menu_page"};
          if (got.length !== want.length)     bad = {bad, " length_setting"};
          if (got.quantity !== want.quantity) bad = {bad, " quantity_left"};
          if (bad != "") begin
            fault_total++;
            if (fault_total <= 10) begin
              $display("[%0t] result mismatch in%s", $realtime, bad);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
    end
    mismatch_count <= fault_total;
    waiting_count <= panel_queue.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the cut cycle sequencer testbench: clock, reset, register profiles,
// button stimulus, receiver stalls, watchdog and verdict.
// Depends on ccsbm_pkg, the block and cutter_behavior_check.
module tb;
  import ccsbm_pkg::*;

  // No beat at all for this many cycles means the block has hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to let the block settle after the last result beat.
  localparam int SETTLE_CYCLES = 6;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SOME,
    STALL_HEAVY
  } stall_mode_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                in_button_level;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_motor_on;
  logic                out_servo_enabled;
  logic [7:0]          out_servo_compare;
  logic                out_status_led;
  logic                out_running;
  logic [1:0]          out_menu_page;
  logic [5:0]          out_length_setting;
  logic [5:0]          out_quantity_left;

  int mismatch_count, waiting_count, ticks_seen, runs_started, pieces_cut, page_steps;

  // Sender pacing: beats left in the current burst.
  int          burst_left;
  // Caps that keep random press and release lengths near the live timing
  // registers, so the menu is actually reached even when those are small.
  int          press_cap, release_cap;
  int          profiles_loaded;
  int          quiet_cycles;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;

  cut_cycle_sequencer_with_button_menu dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_button_level    (in_button_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motor_on       (out_motor_on),
    .out_servo_enabled  (out_servo_enabled),
    .out_servo_compare  (out_servo_compare),
    .out_status_led     (out_status_led),
    .out_running        (out_running),
    .out_menu_page      (out_menu_page),
    .out_length_setting (out_length_setting),
    .out_quantity_left  (out_quantity_left)
  );

  cutter_behavior_check behavior_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_button_level    (in_button_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motor_on       (out_motor_on),
    .out_servo_enabled  (out_servo_enabled),
    .out_servo_compare  (out_servo_compare),
    .out_status_led     (out_status_led),
    .out_running        (out_running),
    .out_menu_page      (out_menu_page),
    .out_length_setting (out_length_setting),
    .out_quantity_left  (out_quantity_left),
    .mismatch_count     (mismatch_count),
    .waiting_count      (waiting_count),
    .ticks_seen         (ticks_seen),
    .runs_started       (runs_started),
    .pieces_cut         (pieces_cut),
    .page_steps         (page_steps)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver changes its habit after a random span: sometimes it never
  // stalls, sometimes now and then, sometimes most of the time. That moves the
  // stalls across every phase of the cut cycle over the run.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_span <= $urandom_range(8, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_SOME:  out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= 1'b0;
    endcase
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one tick beat and waits for the edge that takes it. Valid stays
  // high into the next beat while the burst lasts; after the burst it drops
  // for a random gap before the task returns.
  task automatic send_tick(input logic level);
    in_valid <= 1'b1;
    in_button_level <= level;
    do @(posedge clk); while (in_stall);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Holds the button at one level for a number of milliseconds.
  task automatic hold_level(input logic level, input int ms);
    repeat (ms) send_tick(level);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes all eight registers back to back; the block is idle when called.
  task automatic load_profile(input logic [15:0] debounce, input logic [15:0] long_press,
                              input logic [7:0] feed, input logic [15:0] hold,
                              input logic [7:0] cut_pos, input logic [7:0] rest_pos,
                              input logic [5:0] len_max, input logic [5:0] qty_max);
    write_reg(CFG_DEBOUNCE_MS, debounce);
    write_reg(CFG_LONG_PRESS_MS, long_press);
    write_reg(CFG_FEED_MS_UNIT, {8'd0, feed});
    write_reg(CFG_SERVO_HOLD_MS, hold);
    write_reg(CFG_CUT_POSITION, {8'd0, cut_pos});
    write_reg(CFG_REST_POSITION, {8'd0, rest_pos});
    write_reg(CFG_LENGTH_MAX, {10'd0, len_max});
    write_reg(CFG_QUANTITY_MAX, {10'd0, qty_max});
    cfg_wr_en <= 1'b0;
    press_cap = (long_press > 12) ? 12 : long_press;
    release_cap = (debounce > 6) ? 6 : debounce;
    profiles_loaded++;
  endtask

  // Stops offering ticks, waits until every predicted result has come back,
  // then lets the pipe run dry before the next register write or the verdict.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting_count != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Mostly well-formed press/release pairs: seven in ten presses short enough
  // to act on the page, the rest held past the long-press time. One pair in
  // ten is replaced by bounce noise of random levels.
  task automatic random_phase(input int ticks);
    int sent;
    int dur;
    sent = 0;
    while (sent < ticks) begin
      if ($urandom_range(0, 9) == 0) begin
        dur = $urandom_range(1, 4);
        repeat (dur) send_tick(1'($urandom_range(0, 1)));
        sent += dur;
      end else begin
        if ($urandom_range(0, 9) < 7)
          dur = $urandom_range(1, (press_cap > 0) ? press_cap : 1);
        else
          dur = press_cap + $urandom_range(1, 6);
        hold_level(1'b0, dur);
        sent += dur;
        dur = release_cap + $urandom_range(1, 6);
        hold_level(1'b1, dur);
        sent += dur;
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_DEBOUNCE_MS;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_button_level <= 1'b1;
    burst_left = 20;
    press_cap = 12;
    release_cap = 6;
    profiles_loaded = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: the stop sequence that follows reset starts here, and a
    // brief press is still far too short for the default debounce.
    hold_level(1'b1, 3);
    hold_level(1'b0, 3);
    hold_level(1'b1, 2);
    drain(SETTLE_CYCLES);

    // Fastest timing: no debounce, no servo hold, both maxima at five so
    // each step of a setting wraps at once. Position extremes on the servo.
    load_profile(16'd0, 16'd3, 8'd1, 16'd0, 8'd255, 8'd0, 6'd5, 6'd5);
    hold_level(1'b1, 2);
    // Short press on the start page starts a run.
    hold_level(1'b0, 1);
    hold_level(1'b1, 4);
    // Long press moves to the length page; the release does nothing else.
    hold_level(1'b0, 5);
    hold_level(1'b1, 2);
    // Length steps past its maximum and wraps back to five.
    hold_level(1'b0, 1);
    hold_level(1'b1, 2);
    // Long press to the quantity page, then a short press that wraps the
    // quantity and stores it as the preset.
    hold_level(1'b0, 5);
    hold_level(1'b1, 2);
    hold_level(1'b0, 1);
    hold_level(1'b1, 2);
    drain(SETTLE_CYCLES);

    // Every timing register at its top: the button never settles and the
    // feed of a running cycle lasts far longer than this phase.
    load_profile(16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 8'd0, 8'd255, 6'd63, 6'd63);
    random_phase(30);
    drain(SETTLE_CYCLES);

    // Zero long-press time turns any press held for two ticks or more into a
    // long one that only moves the page; a single-tick press still acts.
    // The length maximum below five forces every length step to five.
    load_profile(16'd0, 16'd0, 8'd1, 16'd2, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 6'd0, 6'd63);
    random_phase(40);
    drain(SETTLE_CYCLES);

    // Short random timings keep whole cut cycles inside each phase, so runs
    // finish, count down to the preset and stop on their own.
    repeat (6) begin
      int dbn;
      dbn = $urandom_range(0, 3);
      load_profile(16'(dbn), 16'($urandom_range(dbn + 2, 14)), 8'($urandom_range(1, 3)),
                   16'($urandom_range(0, 4)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)),
                   6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                   : $urandom_range(5, 63)),
                   6'($urandom_range(0, 63)));
      random_phase(100);
      drain(SETTLE_CYCLES);
    end

    // Back to the reset values, written explicitly this time.
    load_profile(DEBOUNCE_MS_RST, LONG_PRESS_MS_RST, FEED_MS_UNIT_RST, SERVO_HOLD_MS_RST,
                 CUT_POSITION_RST, REST_POSITION_RST, LENGTH_MAX_RST, QUANTITY_MAX_RST);
    random_phase(30);
    drain(SETTLE_CYCLES);

    $display("Checked %0d tick beats under %0d register profiles.",
             ticks_seen, profiles_loaded);
    $display("Runs started: %0d, pieces cut: %0d, menu page steps: %0d.",
             runs_started, pieces_cut, page_steps);
    if (mismatch_count == 0 && waiting_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
